@@ src/mpq_pkg.sv @@
// shared constants, codes and interface structs for the multilevel priority fifo
// no dependencies; used by mpq_ctrl and multilevel_priority_fifo_core
`default_nettype none
package mpq_pkg;

	// configuration of the queue
	localparam int LEVELS      = 8;
	localparam int LEVEL_DEPTH = 16;
	localparam int HANDLE_BITS = 8;

	// fixed port field widths
	localparam int PRIO_W   = 4;
	localparam int HANDLE_W = 8;
	localparam int CFG_W    = 4;
	localparam int STATUS_W = 2;

	// derived widths
	localparam int LEVEL_W   = $clog2(LEVELS);
	localparam int PTR_W     = $clog2(LEVEL_DEPTH);
	localparam int COUNT_W   = $clog2(LEVEL_DEPTH + 1);
	localparam int STORE_W   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int ADDR_W    = LEVEL_W + PTR_W;
	localparam int MEM_DEPTH = LEVELS << PTR_W;

	// reset value of the active level count
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// handle store access from the controller
	typedef struct packed {
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [STORE_W-1:0] wr_data;
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
	} mem_req_t;

	// outcome of one item, handle data follows from the store in the next cycle
	typedef struct packed {
		status_t           status;
		logic [PRIO_W-1:0] level;
		logic              pop_ok;
	} result_t;

endpackage
`default_nettype wire

@@ src/mpq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ src/mpq_ctrl.sv @@
// per-level head, tail and count registers, push and pop decision, store addressing
// depends on mpq_pkg
`default_nettype none
module mpq_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire mpq_pkg::op_t                  op,
	input  wire logic [mpq_pkg::PRIO_W-1:0]    prio,
	input  wire logic [mpq_pkg::HANDLE_W-1:0]  handle,
	input  wire logic [mpq_pkg::CFG_W-1:0]     active,
	output mpq_pkg::mem_req_t                  mem,
	output mpq_pkg::result_t                   res
);

	logic [mpq_pkg::PTR_W-1:0]   head_q  [mpq_pkg::LEVELS];
	logic [mpq_pkg::PTR_W-1:0]   tail_q  [mpq_pkg::LEVELS];
	logic [mpq_pkg::COUNT_W-1:0] count_q [mpq_pkg::LEVELS];

	logic [mpq_pkg::LEVEL_W-1:0] push_lv;
	logic [mpq_pkg::LEVEL_W-1:0] pop_lv;
	logic                        in_range;
	logic                        level_full;
	logic                        found;
	logic                        do_push;
	logic                        do_pop;
	logic                        any_over;

	// wrap-around pointer increment
	function automatic logic [mpq_pkg::PTR_W-1:0] ptr_next(input logic [mpq_pkg::PTR_W-1:0] p);
		return (p == mpq_pkg::PTR_W'(mpq_pkg::LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// lowest-numbered non-empty active level
	always_comb begin
		found  = 1'b0;
		pop_lv = '0;
		for (int i = mpq_pkg::LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0 && mpq_pkg::PRIO_W'(i) < active) begin
				found  = 1'b1;
				pop_lv = mpq_pkg::LEVEL_W'(i);
			end
		end
	end

	// push checks
	always_comb begin
		push_lv    = mpq_pkg::LEVEL_W'(prio - 1'b1);
		in_range   = (prio != '0) && (prio <= active);
		level_full = count_q[push_lv] >= mpq_pkg::COUNT_W'(mpq_pkg::LEVEL_DEPTH);
	end

	// decision and result
	always_comb begin
		do_push    = 1'b0;
		do_pop     = 1'b0;
		res.status = mpq_pkg::ST_OK;
		case (op)
			mpq_pkg::OP_PUSH: begin
				if (!in_range) begin
					res.status = mpq_pkg::ST_RANGE;
				end else if (level_full) begin
					res.status = mpq_pkg::ST_FULL;
				end else begin
					do_push = 1'b1;
				end
			end
			mpq_pkg::OP_POP: begin
				if (found) begin
					do_pop = 1'b1;
				end else begin
					res.status = mpq_pkg::ST_EMPTY;
				end
			end
			default: begin
				res.status = mpq_pkg::ST_EMPTY;
			end
		endcase
		res.pop_ok = do_pop;
		res.level  = do_pop ? mpq_pkg::PRIO_W'(pop_lv) + 1'b1 : '0;
	end

	// store access
	always_comb begin
		mem.wr_en   = accept && do_push;
		mem.wr_addr = {push_lv, tail_q[push_lv]};
		mem.wr_data = handle[mpq_pkg::STORE_W-1:0];
		mem.rd_en   = accept && do_pop;
		mem.rd_addr = {pop_lv, head_q[pop_lv]};
	end

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mpq_pkg::LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (accept) begin
			if (do_push) begin
				tail_q[push_lv]  <= ptr_next(tail_q[push_lv]);
				count_q[push_lv] <= count_q[push_lv] + 1'b1;
			end
			if (do_pop) begin
				head_q[pop_lv]  <= ptr_next(head_q[pop_lv]);
				count_q[pop_lv] <= count_q[pop_lv] - 1'b1;
			end
		end
	end

	// any level above its depth
	always_comb begin
		any_over = 1'b0;
		for (int i = 0; i < mpq_pkg::LEVELS; i++) begin
			if (count_q[i] > mpq_pkg::COUNT_W'(mpq_pkg::LEVEL_DEPTH)) begin
				any_over = 1'b1;
			end
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) !any_over)
		else $error("level count above depth");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem.wr_en && mem.rd_en))
		else $error("store written and read for one item");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mem.rd_en |-> count_q[pop_lv] != '0)
		else $error("pop from an empty level");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		mem.wr_en |=> count_q[$past(push_lv)] == $past(count_q[push_lv]) + 1'b1)
		else $error("push did not grow its level");

endmodule
`default_nettype wire

@@ src/multilevel_priority_fifo_core.sv @@
// top level of the multilevel priority fifo: stream ports, config register,
// result stage and output register; depends on mpq_pkg, mpq_ctrl, mpq_ram
//
// usage:
//   s_axis carries one request item: tuser = operation (0 push, 1 pop),
//   tdata = priority_req and item_handle. m_axis returns one status item per
//   request, in order. cfg writes levels_in_use (reset 4), values above the
//   level count act as the level count; write it only while the block is idle.
// path: the result stage loads at the accepting edge and the output register
//   loads from it once it is free or being taken, so a result reaches m_axis
//   through the result stage and then the output register.
// throughput: one item per cycle while m_axis_tready holds; the handle store takes
//   at most one access per item and the per-level pointers update in the cycle of acceptance.
// reset: all levels empty, pointers at zero, no result pending; the handle
//   store is not cleared and is only read where a push wrote it.
// stall: a result waiting on m_axis holds; one more result waits in the
//   result stage, after which s_axis_tready drops until m_axis_tready.
`default_nettype none
module multilevel_priority_fifo_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // priority_req[3:0], item_handle[11:4], zero
	input  wire logic        s_axis_tuser,  // operation[0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // status[1:0], popped_handle[9:2],
	                                        // popped_level[13:10], zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data
);

	logic [mpq_pkg::CFG_W-1:0]   levels_q;
	logic [mpq_pkg::CFG_W-1:0]   active;
	logic                        accept;
	logic                        move;
	mpq_pkg::mem_req_t           mem;
	mpq_pkg::result_t            res;
	logic [mpq_pkg::STORE_W-1:0] rd_data;

	logic                        valid_s1;
	mpq_pkg::result_t            res_s1;

	logic                         m_valid_q;
	logic [mpq_pkg::STATUS_W-1:0] status_q;
	logic [mpq_pkg::HANDLE_W-1:0] handle_q;
	logic [mpq_pkg::PRIO_W-1:0]   level_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= mpq_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			levels_q <= cfg_data;
		end
	end
	assign active = (levels_q > mpq_pkg::CFG_W'(mpq_pkg::LEVELS))
		? mpq_pkg::CFG_W'(mpq_pkg::LEVELS) : levels_q;

	// handshake
	assign move          = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || move;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (mpq_pkg::op_t'(s_axis_tuser)),
		.prio   (s_axis_tdata[3:0]),
		.handle (s_axis_tdata[11:4]),
		.active (active),
		.mem    (mem),
		.res    (res)
	);

	mpq_ram #(
		.WIDTH (mpq_pkg::STORE_W),
		.DEPTH (mpq_pkg::MEM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_addr),
		.wr_data (mem.wr_data),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_addr),
		.rd_data (rd_data)
	);

	// result stage, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (move) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (move) begin
			status_q <= res_s1.status;
			level_q  <= res_s1.level;
			handle_q <= res_s1.pop_ok ? mpq_pkg::HANDLE_W'(rd_data) : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, level_q, handle_q, status_q};

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking bench for multilevel_priority_fifo_core: drives push and pop items,
// predicts each status item in step with acceptance and compares on m_axis
// depends on mpq_pkg and the core with its submodules
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);

	// one expected status item
	typedef struct {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   level;
	} queue_status_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // priority_req[3:0], item_handle[11:4], zero
	logic        s_axis_tuser;   // operation[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // status[1:0], popped_handle[9:2], popped_level[13:10], zero
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;

	// shadow of the ready queue
	logic [HANDLE_W-1:0] shadow_store [LEVELS][LEVEL_DEPTH];
	int                  shadow_head [LEVELS];
	int                  shadow_tail [LEVELS];
	int                  shadow_fill [LEVELS];
	logic [CFG_W-1:0]    levels_setting;

	queue_status_t pending_status [$];
	int            failures;
	int            mismatches_shown;
	int            burst_left;
	bit            sender_gaps;
	int            hold_request;
	int            cycle_count;

	multilevel_priority_fifo_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	function automatic int active_level_count();
		return (levels_setting > LEVELS) ? LEVELS : int'(levels_setting);
	endfunction

	// apply one request to the shadow queue and return its status item
	function automatic queue_status_t predict_queue_op(op_t op, logic [PRIO_W-1:0] prio,
		logic [HANDLE_W-1:0] handle);
		queue_status_t r;
		int n;
		int lv;
		bit found;
		n = active_level_count();
		r.status = ST_OK;
		r.handle = '0;
		r.level = '0;
		found = 1'b0;
		if (op == OP_PUSH) begin
			if (prio == 0 || prio > n) begin
				r.status = ST_RANGE;
			end else begin
				lv = int'(prio) - 1;
				if (shadow_fill[lv] >= LEVEL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_store[lv][shadow_tail[lv]] = handle & HANDLE_MASK;
					shadow_tail[lv] = (shadow_tail[lv] + 1) % LEVEL_DEPTH;
					shadow_fill[lv]++;
				end
			end
		end else begin
			r.status = ST_EMPTY;
			for (lv = 0; lv < n; lv++) begin
				if (!found && shadow_fill[lv] != 0) begin
					r.handle = shadow_store[lv][shadow_head[lv]] & HANDLE_MASK;
					shadow_head[lv] = (shadow_head[lv] + 1) % LEVEL_DEPTH;
					shadow_fill[lv]--;
					r.level = PRIO_W'(lv + 1);
					r.status = ST_OK;
					found = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic note_failure(string msg);
		if (mismatches_shown < 10) begin
			$display("%s", msg);
			mismatches_shown++;
		end
		failures++;
	endtask

	// offer one request item, bursts with random gaps in front
	task automatic send_request(op_t op, logic [PRIO_W-1:0] prio, logic [HANDLE_W-1:0] handle);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = {4'h0, handle, prio};
		do @(posedge clk); while (!s_axis_tready);
		pending_status.push_back(predict_queue_op(op, prio, handle));
		@(negedge clk);
	endtask

	// mostly well-formed pushes, about one in ten with any priority value; pops carry any priority value
	task automatic send_random_request(int push_pct);
		op_t op;
		logic [PRIO_W-1:0] prio;
		int n;
		bit stray;
		n = active_level_count();
		stray = ($urandom_range(0, 99) < 10);
		op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
		if (op == OP_PUSH && !stray && n > 0)
			prio = PRIO_W'($urandom_range(1, n));
		else
			prio = PRIO_W'($urandom_range(0, 15));
		send_request(op, prio, HANDLE_W'($urandom));
	endtask

	// wait until every status item is back, plus the result pipeline
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (pending_status.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_levels(logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		levels_setting = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// reset setting of four levels: range checks and empty pop
	task automatic test_reset_levels();
		send_request(OP_POP, 4'd0, 8'h00);
		send_request(OP_PUSH, 4'd0, 8'h00);
		send_request(OP_PUSH, 4'd5, 8'hFF);
		send_request(OP_PUSH, 4'd15, 8'hFF);
		send_request(OP_PUSH, 4'd4, 8'hFF);
		send_request(OP_PUSH, 4'd1, 8'h00);
	endtask

	// pops come out most urgent level first, fifo order within a level
	task automatic test_pop_order();
		send_request(OP_PUSH, 4'd2, 8'hA5);
		send_request(OP_PUSH, 4'd1, 8'h5A);
		send_request(OP_PUSH, 4'd3, 8'h3C);
		repeat (6) send_request(OP_POP, PRIO_W'($urandom_range(0, 15)), HANDLE_W'($urandom));
	endtask

	// levels outside the setting keep their handles; zero and oversized settings
	task automatic test_hidden_levels();
		write_levels(4'd8);
		send_request(OP_PUSH, 4'd8, 8'hC3);
		send_request(OP_PUSH, 4'd6, 8'h81);
		write_levels(4'd1);
		send_request(OP_PUSH, 4'd2, 8'h11);
		send_request(OP_POP, 4'd1, 8'h00);
		write_levels(4'd0);
		send_request(OP_PUSH, 4'd1, 8'h22);
		send_request(OP_POP, 4'd0, 8'h00);
		write_levels(4'd15);
		send_request(OP_PUSH, 4'd9, 8'h33);
		repeat (3) send_request(OP_POP, 4'd0, 8'h00);
	endtask

	// fill levels past full, partial drain so the pointers wrap, refill, drain
	task automatic test_full_levels();
		logic [PRIO_W-1:0] lv;
		write_levels(4'd8);
		repeat (3) begin
			lv = PRIO_W'($urandom_range(1, LEVELS));
			repeat (18) send_request(OP_PUSH, lv, HANDLE_W'($urandom));
			repeat (8) send_request(OP_POP, PRIO_W'($urandom_range(0, 15)), HANDLE_W'($urandom));
			repeat (10) send_request(OP_PUSH, lv, HANDLE_W'($urandom));
			repeat (17) send_request(OP_POP, PRIO_W'($urandom_range(0, 15)), HANDLE_W'($urandom));
		end
	endtask

	// receiver holds off for a long stretch while items keep coming
	task automatic test_backpressure();
		write_levels(4'd8);
		sender_gaps = 1'b0;
		hold_request = 100;
		repeat (40) send_random_request(70);
		sender_gaps = 1'b1;
	endtask

	// random phases under changing level settings and push mixes
	task automatic test_random_mix();
		logic [CFG_W-1:0] setting;
		int push_pct;
		repeat (9) begin
			case ($urandom_range(0, 5))
				0: setting = 4'd1;
				1: setting = 4'd8;
				2: setting = CFG_W'($urandom_range(9, 15));
				default: setting = CFG_W'($urandom_range(1, 8));
			endcase
			write_levels(setting);
			case ($urandom_range(0, 3))
				0: push_pct = 30;
				1: push_pct = 50;
				2: push_pct = 70;
				default: push_pct = 85;
			endcase
			repeat (47) send_random_request(push_pct);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int mode;
		int left;
		int hold_left;
		int tick;
		m_axis_tready = 1'b0;
		mode = 0;
		left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(8, 60);
				end
				left--;
				tick++;
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = ($urandom_range(0, 3) != 0);
					2: m_axis_tready = ($urandom_range(0, 1) == 1);
					default: m_axis_tready = (tick % 5 != 0);
				endcase
			end
		end
	end

	// compare each status item with the oldest expectation
	always @(posedge clk) begin
		queue_status_t want;
		status_t got_status;
		logic [HANDLE_W-1:0] got_handle;
		logic [PRIO_W-1:0] got_level;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status = status_t'(m_axis_tdata[1:0]);
			got_handle = m_axis_tdata[9:2];
			got_level = m_axis_tdata[13:10];
			if (pending_status.size() == 0) begin
				note_failure($sformatf("unexpected item: status %0d handle %02h level %0d",
					got_status, got_handle, got_level));
			end else begin
				want = pending_status.pop_front();
				if (got_status != want.status || got_handle != want.handle ||
					got_level != want.level)
					note_failure($sformatf(
						"mismatch: expected status %0d handle %02h level %0d, got %0d %02h %0d",
						want.status, want.handle, want.level, got_status, got_handle, got_level));
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// main sequence
	initial begin
		int lv;
		int p;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		failures = 0;
		mismatches_shown = 0;
		burst_left = 0;
		sender_gaps = 1'b1;
		hold_request = 0;
		levels_setting = CFG_RESET;
		for (lv = 0; lv < LEVELS; lv++) begin
			shadow_head[lv] = 0;
			shadow_tail[lv] = 0;
			shadow_fill[lv] = 0;
			for (p = 0; p < LEVEL_DEPTH; p++) shadow_store[lv][p] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_levels();
		test_pop_order();
		test_hidden_levels();
		test_full_levels();
		test_backpressure();
		test_random_mix();

		wait_idle();
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
